@@ rtl/p2c_pkg.sv @@
// Package for the polar-to-cartesian (degrees) CORDIC core.
// Holds datapath widths, angle fold constants, the degree arctangent table
// and the vector type passed between rotation stages. No dependencies.
package p2c_pkg;

  localparam int unsigned MAG_W     = 16;
  localparam int unsigned ANG_W     = 16;
  localparam int unsigned RES_W     = 14;   // folded angle, +-90 degrees in 1/64 units
  localparam int unsigned OUT_W     = 17;
  localparam int unsigned XY_W      = 27;
  localparam int unsigned Z_W       = 26;
  localparam int unsigned GAIN_W    = 30;
  localparam int unsigned PROD_W    = MAG_W + GAIN_W + 1;
  localparam int unsigned TABLE_LEN = 24;

  localparam logic [GAIN_W-1:0]       INV_GAIN_Q30 = 30'd652032874;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 16'sd5760;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 16'sd11520;
  localparam logic signed [ANG_W-1:0] FULL_TURN    = 16'sd23040;
  localparam int                      OUT_MAX      = 65535;

  // atan(2^-i) in degrees, scaled by 2^16
  localparam logic signed [Z_W-1:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   neg;
  } p2c_vec_t;

endpackage

@@ rtl/p2c_rot_stage.sv @@
// One registered CORDIC rotation stage with a fixed shift.
// Depends on p2c_pkg for the vector type and the arctangent table.
module p2c_rot_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_ready,
  input  p2c_pkg::p2c_vec_t src_vec,
  output logic              dst_valid,
  input  logic              dst_ready,
  output p2c_pkg::p2c_vec_t dst_vec
);
  import p2c_pkg::*;

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  p2c_vec_t               rot;

  assign src_ready = !dst_valid || dst_ready;

  always_comb begin
    dx      = src_vec.y >>> SHIFT;
    dy      = src_vec.x >>> SHIFT;
    rot.neg = src_vec.neg;
    if (!src_vec.z[Z_W-1]) begin
      rot.x = src_vec.x - dx;
      rot.y = src_vec.y + dy;
      rot.z = src_vec.z - ATAN_DEG_Q16[SHIFT];
    end else begin
      rot.x = src_vec.x + dx;
      rot.y = src_vec.y - dy;
      rot.z = src_vec.z + ATAN_DEG_Q16[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (src_ready) begin
      dst_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_ready && src_valid) begin
      dst_vec <= rot;
    end
  end

endmodule

@@ rtl/polar_to_cartesian_degrees_core.sv @@
// Polar (magnitude, degrees) to cartesian CORDIC core, top level.
// Depends on p2c_pkg and p2c_rot_stage.
//
// Takes one transfer per clock unless stalled and returns x = r*cos(a),
// y = r*sin(a) as signed Q17.0 integers, one result per input, in order.
// Registers in order: angle clamp and fold, gain multiply, one per unrolled
// rotation stage, then rounding and saturation into the output register.
// Unstalled, the sustained rate is one item per cycle, set by the fully
// unrolled rotation pipeline; each stage holds its item while the next is
// full, so m_tready backpressure stalls the pipe without loss; bubbles collapse.
module polar_to_cartesian_degrees_core #(
  parameter int unsigned ROTATION_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] magnitude, [31:16] angle_deg
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [16:0] x_coord, [33:17] y_coord, [39:34] zero
);
  import p2c_pkg::*;

  localparam int unsigned N = ROTATION_STAGES;
  localparam int unsigned RND_W = XY_W + 1;
  localparam int unsigned SAT_W = RND_W - 8 + 1;

  // angle clamp and fold
  logic signed [ANG_W-1:0] ang_in;
  logic signed [ANG_W-1:0] ang_clamp;
  logic signed [ANG_W-1:0] ang_turn;
  logic signed [ANG_W-1:0] ang_fold;
  logic                    fold_neg;

  logic                    a_valid;
  logic                    a_ready;
  logic [MAG_W-1:0]        a_mag;
  logic signed [RES_W-1:0] a_ang;
  logic                    a_neg;

  logic [PROD_W-1:0]       prod;
  p2c_vec_t                gain_vec;

  logic [N:0]              vld;
  logic [N:0]              take;
  p2c_vec_t                vec [N+1];

  logic                    out_ready;
  logic signed [OUT_W-1:0] x_fin;
  logic signed [OUT_W-1:0] y_fin;

  function automatic logic signed [OUT_W-1:0] finish(input logic signed [XY_W-1:0] v,
                                                     input logic neg);
    logic signed [RND_W-1:0] t;
    logic signed [SAT_W-1:0] r;
    t = RND_W'(v) + RND_W'(128);
    r = SAT_W'(t >>> 8);
    if (neg) begin
      r = -r;
    end
    if (r > SAT_W'(OUT_MAX)) begin
      r = SAT_W'(OUT_MAX);
    end else if (r < -SAT_W'(OUT_MAX)) begin
      r = -SAT_W'(OUT_MAX);
    end
    return r[OUT_W-1:0];
  endfunction

  assign ang_in = $signed(s_tdata[31:16]);

  always_comb begin
    ang_clamp = ang_in;
    if (ang_in > FULL_TURN) begin
      ang_clamp = FULL_TURN;
    end else if (ang_in < -FULL_TURN) begin
      ang_clamp = -FULL_TURN;
    end
    ang_turn = ang_clamp;
    if (ang_clamp > HALF_TURN) begin
      ang_turn = ang_clamp - FULL_TURN;
    end else if (ang_clamp < -HALF_TURN) begin
      ang_turn = ang_clamp + FULL_TURN;
    end
    ang_fold = ang_turn;
    fold_neg = 1'b0;
    if (ang_turn > QUARTER_TURN) begin
      ang_fold = ang_turn - HALF_TURN;
      fold_neg = 1'b1;
    end else if (ang_turn < -QUARTER_TURN) begin
      ang_fold = ang_turn + HALF_TURN;
      fold_neg = 1'b1;
    end
  end

  assign s_tready = !a_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      a_mag <= s_tdata[15:0];
      a_ang <= ang_fold[RES_W-1:0];
      a_neg <= fold_neg;
    end
  end

  // gain stage: x0 = round(mag / K) with 8 fraction bits, z0 in 2^-16 degree
  always_comb begin
    prod         = PROD_W'(a_mag) * PROD_W'(INV_GAIN_Q30) + (PROD_W'(1) << 21);
    gain_vec.x   = XY_W'(prod[PROD_W-1:22]);
    gain_vec.y   = '0;
    gain_vec.z   = Z_W'($signed({a_ang, 10'b0}));
    gain_vec.neg = a_neg;
  end

  assign a_ready = !vld[0] || take[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (a_ready) begin
      vld[0] <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && a_valid) begin
      vec[0] <= gain_vec;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    p2c_rot_stage #(
      .SHIFT(i)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .src_valid(vld[i]),
      .src_ready(take[i]),
      .src_vec  (vec[i]),
      .dst_valid(vld[i+1]),
      .dst_ready(take[i+1]),
      .dst_vec  (vec[i+1])
    );
  end

  // output register
  assign out_ready = !m_tvalid || m_tready;
  assign take[N]   = out_ready;
  assign x_fin     = finish(vec[N].x, vec[N].neg);
  assign y_fin     = finish(vec[N].y, vec[N].neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && vld[N]) begin
      m_tdata <= {6'b0, y_fin, x_fin};
    end
  end

`ifndef SYNTHESIS
  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> (a_ang <= 14'sd5760 && a_ang >= -14'sd5760))
    else $error("folded angle outside +-90 degrees");

  a_gain_pos: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> !vec[0].x[XY_W-1])
    else $error("gain stage produced negative x");

  a_out_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[16:0] != 17'h10000 && m_tdata[33:17] != 17'h10000))
    else $error("output escaped saturation");

  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !a_valid |-> s_tready)
    else $error("input stalled with empty first stage");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (vld[N] && out_ready) |=> m_tvalid)
    else $error("finished item not loaded into output register");
`endif

endmodule

@@ bench/polar_to_cartesian_degrees_checker.sv @@
// Scoreboard for polar_to_cartesian_degrees_core: predicts x/y per input transfer
// and compares each output transfer in order. Uses no package items; stands on
// its own CORDIC model with a private degree arctangent table.
`timescale 1ns / 1ps

module polar_to_cartesian_degrees_checker #(
  parameter int unsigned ROTATION_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] magnitude, [31:16] angle_deg
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [16:0] x_coord, [33:17] y_coord, [39:34] zero
  output int          fail_count,
  output int          rect_pending
);

  localparam longint GAIN_Q30   = 652032874;
  localparam longint QTR_TURN   = 5760;
  localparam longint HLF_TURN   = 11520;
  localparam longint FUL_TURN   = 23040;
  localparam longint COORD_MAX  = 65535;
  localparam int     ATAN_COUNT = 24;

  localparam longint ATAN_Q16 [ATAN_COUNT] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
  } rect_t;

  rect_t rect_due[$];

  initial begin
    fail_count   = 0;
    rect_pending = 0;
  end

  function automatic logic signed [16:0] round_coord(input longint v, input bit fold);
    longint r;
    r = (v + 128) >>> 8;
    if (fold) r = -r;
    if (r > COORD_MAX) r = COORD_MAX;
    if (r < -COORD_MAX) r = -COORD_MAX;
    return r[16:0];
  endfunction

  function automatic rect_t rotate_polar(input logic [15:0] mag,
                                         input logic signed [15:0] ang);
    longint m, a, x, y, z, dx, dy;
    bit     fold;
    rect_t  res;
    m    = mag;
    a    = ang;
    fold = 1'b0;
    if (a > FUL_TURN) a = FUL_TURN;
    if (a < -FUL_TURN) a = -FUL_TURN;
    if (a > HLF_TURN) a -= FUL_TURN;
    if (a < -HLF_TURN) a += FUL_TURN;
    if (a > QTR_TURN) begin
      a -= HLF_TURN;
      fold = 1'b1;
    end else if (a < -QTR_TURN) begin
      a += HLF_TURN;
      fold = 1'b1;
    end
    x = (m * GAIN_Q30 + (64'sd1 <<< 21)) >>> 22;
    y = 0;
    z = a * 1024;
    for (int i = 0; i < int'(ROTATION_STAGES) && i < ATAN_COUNT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_Q16[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_Q16[i];
      end
    end
    res.x = round_coord(x, fold);
    res.y = round_coord(y, fold);
    return res;
  endfunction

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    rect_t got;
    rect_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.x = m_tdata[16:0];
        got.y = m_tdata[33:17];
        if (rect_due.size() == 0) begin
          flag_error($sformatf("unexpected transfer x=%0d y=%0d", got.x, got.y));
        end else begin
          want = rect_due.pop_front();
          if (got.x !== want.x || got.y !== want.y)
            flag_error($sformatf("x exp %0d got %0d, y exp %0d got %0d",
                                 want.x, got.x, want.y, got.y));
        end
      end
      if (s_tvalid && s_tready)
        rect_due.push_back(rotate_polar(s_tdata[15:0], s_tdata[31:16]));
      rect_pending = rect_due.size();
    end
  end

endmodule

@@ bench/polar_to_cartesian_degrees_core_test.sv @@
// Testbench top for polar_to_cartesian_degrees_core: drives polar samples with
// random idling on both sides and gives the verdict. Depends on the core and
// polar_to_cartesian_degrees_checker.
`timescale 1ns / 1ps

module polar_to_cartesian_degrees_core_test;

  localparam int unsigned STAGES = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  int fail_count;
  int rect_pending;
  int send_idle_pct = 21;
  int recv_idle_pct = 53;

  polar_to_cartesian_degrees_core #(.ROTATION_STAGES(STAGES)) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  polar_to_cartesian_degrees_checker #(.ROTATION_STAGES(STAGES)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .rect_pending(rect_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= (int'($urandom_range(99)) >= recv_idle_pct);
  end

  task automatic send_polar(input logic [15:0] mag, input logic signed [15:0] ang);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ang, mag};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    int          pick;
    int          a;
    logic [15:0] mag;
    for (int n = 0; n < count; n++) begin
      pick = int'($urandom_range(99));
      mag  = 16'($urandom_range(65535));
      if (pick < 15) mag = 16'($urandom_range(255));
      if (pick < 60)
        a = int'($urandom_range(46080)) - 23040;
      else if (pick < 80)
        a = (int'($urandom_range(8)) - 4) * 5760 + int'($urandom_range(6)) - 3;
      else
        a = int'($urandom_range(65535));
      send_polar(mag, a[15:0]);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // edges of the angle range, quarter-turn boundaries, clamping, full scale
    send_polar(16'd0,     16'sd0);
    send_polar(16'd65535, 16'sd0);
    send_polar(16'd65535, 16'sd2880);
    send_polar(16'd65535, 16'sd5760);
    send_polar(16'd65535, -16'sd5760);
    send_polar(16'd256,   16'sd5759);
    send_polar(16'd256,   16'sd5761);
    send_polar(16'd256,   -16'sd5761);
    send_polar(16'd65535, 16'sd11520);
    send_polar(16'd65535, -16'sd11520);
    send_polar(16'd32768, 16'sd17280);
    send_polar(16'd32768, -16'sd17280);
    send_polar(16'd65535, 16'sd23040);
    send_polar(16'd65535, -16'sd23040);
    send_polar(16'd1,     16'sd23041);
    send_polar(16'd4660,  -16'sd23041);
    send_polar(16'd65535, 16'sh7FFF);
    send_polar(16'd65535, 16'sh8000);
    send_polar(16'd1,     16'sd1);
    send_polar(16'd43690, -16'sd1);

    send_random(170);
    send_idle_pct = 53;
    recv_idle_pct = 21;
    send_random(170);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(170);

    s_tvalid <= 1'b0;
    while (rect_pending != 0) @(posedge clk);
    repeat (STAGES + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
